// ----- sv/idr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Integer divide/remainder unit package
// Shared width, operation codes and item/stage types for the divider pipeline.
// ----------------------------------------------------------------------------
package idr_pkg;

	localparam int DATA_WIDTH = 32;

	// Operation codes
	localparam logic [1:0] CMD_SDIV = 2'd0;
	localparam logic [1:0] CMD_UDIV = 2'd1;
	localparam logic [1:0] CMD_SREM = 2'd2;
	localparam logic [1:0] CMD_UREM = 2'd3;

	typedef struct packed {
		logic [1:0]            command;
		logic [DATA_WIDTH-1:0] dividend;
		logic [DATA_WIDTH-1:0] divisor;
	} idr_req_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] result;
		logic                  divide_by_zero;
	} idr_rsp_t;

	// Per-item control carried down the cell chain
	typedef struct packed {
		logic want_rem;
		logic neg_q;
		logic neg_r;
		logic dz;
	} idr_flags_t;

	// Working state of one item between cells
	typedef struct packed {
		idr_flags_t            flags;
		logic [DATA_WIDTH-1:0] rem;   // partial remainder
		logic [DATA_WIDTH-1:0] nq;    // dividend bits left, quotient bits shifted in below
		logic [DATA_WIDTH-1:0] dsr;   // divisor magnitude
	} idr_stage_t;

endpackage
`default_nettype wire

// ----- sv/integer_divide_remainder_unit.sv -----
`default_nettype none
// Accepted items pass the prep, cell and result registers in turn to result valid.
// Throughput: one item per cycle unless stalled; the chain holds one item per cell.
// The chain is one prep stage, one restoring cell per quotient bit, one result stage.
// Each stage empties into its neighbor whenever that neighbor is free or moving.
// Reset clears all stage valid bits; no item survives reset.
// ----------------------------------------------------------------------------
// Integer divide/remainder unit
// Pipelined restoring divider: signed/unsigned quotient and remainder.
// ----------------------------------------------------------------------------
module integer_divide_remainder_unit
	import idr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire idr_req_t   req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output idr_rsp_t        rsp
);

	// Links between stages: index 0 is the prep output, DATA_WIDTH the last cell
	logic       link_valid [DATA_WIDTH+1];
	logic       link_ready [DATA_WIDTH+1];
	idr_stage_t link_data  [DATA_WIDTH+1];

	idr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_data   (req),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link_data[0])
	);

	// Row of restoring cells, one per quotient bit
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		idr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	idr_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[DATA_WIDTH]),
		.in_ready  (link_ready[DATA_WIDTH]),
		.in_data   (link_data[DATA_WIDTH]),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_data  (rsp)
	);

endmodule
`default_nettype wire

// ----- sv/idr_prep.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Divider operand preparation
// Decodes the operation, takes operand magnitudes and flags divide by zero.
// ----------------------------------------------------------------------------
module idr_prep
	import idr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire idr_req_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output idr_stage_t      out_data
);

	logic                  valid_q;
	idr_stage_t            data_q;
	idr_stage_t            nxt;
	logic                  is_signed;
	logic                  want_rem;
	logic                  na;
	logic                  nb;
	logic                  dz;

	// Decode the operation
	always_comb begin
		unique case (in_data.command)
			CMD_SDIV: begin is_signed = 1'b1; want_rem = 1'b0; end
			CMD_UDIV: begin is_signed = 1'b0; want_rem = 1'b0; end
			CMD_SREM: begin is_signed = 1'b1; want_rem = 1'b1; end
			CMD_UREM: begin is_signed = 1'b0; want_rem = 1'b1; end
			default:  begin is_signed = 1'b0; want_rem = 1'b0; end
		endcase
	end

	// Take magnitudes and sign corrections
	always_comb begin
		na = is_signed & in_data.dividend[DATA_WIDTH-1];
		nb = is_signed & in_data.divisor[DATA_WIDTH-1];
		dz = (in_data.divisor == '0);
		nxt.flags.want_rem = want_rem;
		nxt.flags.neg_q    = (na ^ nb) & ~dz;
		nxt.flags.neg_r    = na;
		nxt.flags.dz       = dz;
		nxt.rem            = '0;
		nxt.nq             = na ? -in_data.dividend : in_data.dividend;
		nxt.dsr            = nb ? -in_data.divisor : in_data.divisor;
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- sv/idr_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider cell
// Shifts one dividend bit into the partial remainder and conditionally subtracts.
// ----------------------------------------------------------------------------
module idr_cell
	import idr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire idr_stage_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output idr_stage_t      out_data
);

	logic                  valid_q;
	idr_stage_t            data_q;
	idr_stage_t            nxt;
	logic [DATA_WIDTH-1:0] trial;
	logic                  carry;
	logic                  take;

	// One restoring step
	always_comb begin
		carry     = in_data.rem[DATA_WIDTH-1];
		trial     = {in_data.rem[DATA_WIDTH-2:0], in_data.nq[DATA_WIDTH-1]};
		take      = carry | (trial >= in_data.dsr);
		nxt.flags = in_data.flags;
		nxt.dsr   = in_data.dsr;
		nxt.rem   = take ? (trial - in_data.dsr) : trial;
		nxt.nq    = {in_data.nq[DATA_WIDTH-2:0], take};
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Advance the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- sv/idr_post.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Divider result stage
// Selects quotient or remainder, applies the sign and holds the result item.
// ----------------------------------------------------------------------------
module idr_post
	import idr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire idr_stage_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output idr_rsp_t        out_data
);

	logic                  valid_q;
	idr_rsp_t              data_q;
	idr_rsp_t              nxt;
	logic [DATA_WIDTH-1:0] sel;
	logic                  neg;

	// Pick the answer and fix its sign
	always_comb begin
		sel = in_data.flags.want_rem ? in_data.rem : in_data.nq;
		neg = in_data.flags.want_rem ? in_data.flags.neg_r : in_data.flags.neg_q;
		nxt.result         = neg ? -sel : sel;
		nxt.divide_by_zero = in_data.flags.dz;
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule
`default_nettype wire
